// ----- src/psfc_pkg.sv -----
// Package for the passive serial configuration sequencer.
// Holds the item codes, the configuration indexes and the burst descriptor type.
// No dependencies.
package psfc_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  localparam logic [1:0] CFG_MAX_ATTEMPTS   = 2'd0;
  localparam logic [1:0] CFG_CHECK_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_INIT_CYCLES    = 2'd2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LOAD = 3'd1;
  localparam logic [2:0] PH_WAIT = 3'd2;

  localparam logic [2:0] ACT_NCFG_LO = 3'd0;
  localparam logic [2:0] ACT_NCFG_HI = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_INIT    = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;
  localparam logic [2:0] ACT_STATUS  = 3'd5;

  localparam logic [2:0] ST_LOADING = 3'd0;
  localparam logic [2:0] ST_RETRY   = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_SUCCESS = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_NCFG = 2'd1;
  localparam logic [1:0] HDR_DATA = 2'd2;

  localparam logic [1:0] SEG_HDR  = 2'd0;
  localparam logic [1:0] SEG_INIT = 2'd1;
  localparam logic [1:0] SEG_TAIL = 2'd2;

  localparam logic [5:0] INIT_MAX = 6'd50;

  typedef struct packed {
    logic [1:0] hdr;
    logic [7:0] data_byte;
    logic [5:0] n_init;
    logic       has_tail;
    logic [2:0] tail_act;
    logic       tail_bit;
    logic [2:0] tail_st;
    logic [3:0] att;
  } desc_t;

endpackage

// ----- src/psfc_ctrl.sv -----
// Sequencer state, configuration registers and the pending burst descriptor.
// Each accepted item updates the state and leaves one descriptor.
// Depends on psfc_pkg.
module psfc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic                 new_job_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 nstatus_i,
  input  logic                 conf_done_i,
  output logic                 pend_valid_o,
  output psfc_pkg::desc_t      pend_desc_o,
  input  logic                 take_i
);

  logic [3:0]  max_att_q;
  logic [15:0] ivl_cfg_q;
  logic [5:0]  init_cfg_q;
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  att_q, att_d;
  logic [15:0] icnt_q, icnt_d;
  logic        pend_valid_q;
  psfc_pkg::desc_t pend_q, desc_d;

  logic        accept;
  logic [3:0]  att_base;
  logic [15:0] ivl;
  logic [16:0] icnt_inc;
  logic        check;
  logic        err;

  assign accept       = in_valid_i && in_ready_o;
  assign in_ready_o   = !pend_valid_q || take_i;
  assign pend_valid_o = pend_valid_q;
  assign pend_desc_o  = pend_q;

  assign att_base = new_job_i ? max_att_q : att_q;
  assign ivl      = (ivl_cfg_q == 16'd0) ? 16'd1 : ivl_cfg_q;
  assign icnt_inc = {1'b0, icnt_q} + 17'd1;
  assign check    = (icnt_q == 16'd0) || last_byte_i;
  assign err      = (check && !nstatus_i) || (last_byte_i && !conf_done_i);

  always_comb begin
    phase_d          = phase_q;
    att_d            = att_q;
    icnt_d           = icnt_q;
    desc_d.hdr       = psfc_pkg::HDR_NONE;
    desc_d.data_byte = data_byte_i;
    desc_d.n_init    = 6'd0;
    desc_d.has_tail  = 1'b1;
    desc_d.tail_act  = psfc_pkg::ACT_STATUS;
    desc_d.tail_bit  = 1'b0;
    desc_d.tail_st   = psfc_pkg::ST_IGNORED;
    if (kind_i == psfc_pkg::KIND_START) begin
      if (att_base == 4'd0) begin
        phase_d        = psfc_pkg::PH_IDLE;
        att_d          = 4'd0;
        desc_d.tail_st = psfc_pkg::ST_FAILED;
      end else begin
        phase_d         = psfc_pkg::PH_LOAD;
        att_d           = att_base - 4'd1;
        icnt_d          = 16'd0;
        desc_d.hdr      = psfc_pkg::HDR_NCFG;
        desc_d.has_tail = 1'b0;
      end
    end else if (kind_i == psfc_pkg::KIND_DATA && phase_q == psfc_pkg::PH_LOAD) begin
      desc_d.hdr = psfc_pkg::HDR_DATA;
      icnt_d     = (icnt_inc >= {1'b0, ivl}) ? 16'd0 : icnt_inc[15:0];
      if (err) begin
        phase_d        = psfc_pkg::PH_IDLE;
        desc_d.tail_st = (att_q != 4'd0) ? psfc_pkg::ST_RETRY : psfc_pkg::ST_FAILED;
      end else if (last_byte_i) begin
        phase_d        = psfc_pkg::PH_WAIT;
        desc_d.n_init  = (init_cfg_q > psfc_pkg::INIT_MAX) ? psfc_pkg::INIT_MAX : init_cfg_q;
        desc_d.tail_st = psfc_pkg::ST_WAIT;
      end else begin
        desc_d.has_tail = 1'b0;
      end
    end else if (kind_i == psfc_pkg::KIND_FINAL && phase_q == psfc_pkg::PH_WAIT) begin
      phase_d = psfc_pkg::PH_IDLE;
      if (nstatus_i && conf_done_i) begin
        desc_d.tail_act = psfc_pkg::ACT_RELEASE;
        desc_d.tail_bit = 1'b1;
        desc_d.tail_st  = psfc_pkg::ST_SUCCESS;
      end else begin
        att_d          = 4'd0;
        desc_d.tail_st = psfc_pkg::ST_FAILED;
      end
    end
    desc_d.att = att_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q    <= 4'd5;
      ivl_cfg_q    <= 16'd10240;
      init_cfg_q   <= 6'd50;
      phase_q      <= psfc_pkg::PH_IDLE;
      att_q        <= 4'd0;
      icnt_q       <= 16'd0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          psfc_pkg::CFG_MAX_ATTEMPTS:   max_att_q  <= cfg_data_i[3:0];
          psfc_pkg::CFG_CHECK_INTERVAL: ivl_cfg_q  <= cfg_data_i;
          psfc_pkg::CFG_INIT_CYCLES:    init_cfg_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q      <= phase_d;
        att_q        <= att_d;
        icnt_q       <= icnt_d;
        pend_valid_q <= 1'b1;
      end else if (take_i) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= desc_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_valid_q)
    else $error("accepted item left no pending descriptor");
  a_pend_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && !take_i) |=> $stable(pend_q))
    else $error("pending descriptor changed while not taken");
  a_take_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> pend_valid_q)
    else $error("descriptor taken from an empty slot");
`endif

endmodule

// ----- src/psfc_emit.sv -----
// Output sequencer: expands one burst descriptor into its result items.
// One result item leaves per cycle while the output is ready, from the registered descriptor and counter.
// Depends on psfc_pkg.
module psfc_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pend_valid_i,
  input  psfc_pkg::desc_t pend_desc_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      action_o,
  output logic            data_bit_o,
  output logic [2:0]      status_o,
  output logic [3:0]      attempts_left_o,
  output logic            last_o
);

  psfc_pkg::desc_t desc_q;
  logic            busy_q;
  logic [1:0]      seg_q, seg_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            seg_end;
  logic            has_next;
  logic [1:0]      next_seg;
  logic [1:0]      first_seg;
  logic            advance;
  logic            finish;

  always_comb begin
    action_o   = desc_q.tail_act;
    data_bit_o = desc_q.tail_bit;
    status_o   = desc_q.tail_st;
    seg_end    = 1'b1;
    unique case (seg_q)
      psfc_pkg::SEG_HDR: begin
        status_o   = psfc_pkg::ST_LOADING;
        data_bit_o = 1'b0;
        if (desc_q.hdr == psfc_pkg::HDR_NCFG) begin
          action_o = cnt_q[0] ? psfc_pkg::ACT_NCFG_HI : psfc_pkg::ACT_NCFG_LO;
          seg_end  = cnt_q[0];
        end else begin
          action_o   = psfc_pkg::ACT_DATA;
          data_bit_o = desc_q.data_byte[cnt_q[2:0]];
          seg_end    = (cnt_q[2:0] == 3'd7);
        end
      end
      psfc_pkg::SEG_INIT: begin
        action_o   = psfc_pkg::ACT_INIT;
        data_bit_o = 1'b0;
        status_o   = psfc_pkg::ST_LOADING;
        seg_end    = (cnt_q == desc_q.n_init - 6'd1);
      end
      default: ;
    endcase
  end

  always_comb begin
    has_next = 1'b0;
    next_seg = psfc_pkg::SEG_TAIL;
    unique case (seg_q)
      psfc_pkg::SEG_HDR: begin
        if (desc_q.n_init != 6'd0) begin
          has_next = 1'b1;
          next_seg = psfc_pkg::SEG_INIT;
        end else begin
          has_next = desc_q.has_tail;
        end
      end
      psfc_pkg::SEG_INIT: has_next = desc_q.has_tail;
      default: ;
    endcase
  end

  assign first_seg = (pend_desc_i.hdr != psfc_pkg::HDR_NONE) ? psfc_pkg::SEG_HDR :
                     (pend_desc_i.n_init != 6'd0) ? psfc_pkg::SEG_INIT : psfc_pkg::SEG_TAIL;

  assign last_o          = seg_end && !has_next;
  assign out_valid_o     = busy_q;
  assign attempts_left_o = desc_q.att;
  assign advance         = busy_q && out_ready_i;
  assign finish          = advance && last_o;
  assign take_o          = pend_valid_i && (!busy_q || finish);

  always_comb begin
    seg_d = seg_q;
    cnt_d = cnt_q;
    if (take_o) begin
      seg_d = first_seg;
      cnt_d = 6'd0;
    end else if (advance) begin
      if (seg_end) begin
        seg_d = next_seg;
        cnt_d = 6'd0;
      end else begin
        cnt_d = cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      seg_q  <= psfc_pkg::SEG_TAIL;
      cnt_q  <= 6'd0;
    end else begin
      seg_q <= seg_d;
      cnt_q <= cnt_d;
      if (take_o) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      desc_q <= pend_desc_i;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_ready_i) |=> ($stable(cnt_q) && $stable(seg_q)))
    else $error("sequencer moved while the output was stalled");
  a_init_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && seg_q == psfc_pkg::SEG_INIT) |-> (cnt_q < desc_q.n_init))
    else $error("init pulse count ran past its limit");
  a_hdr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && seg_q == psfc_pkg::SEG_HDR) |-> (cnt_q < 6'd8))
    else $error("data bit index ran past the byte");
`endif

endmodule

// ----- src/passive_serial_fpga_configurator_top.sv -----
// Top level of the passive serial configuration sequencer.
// Instantiates psfc_ctrl and psfc_emit; depends on psfc_pkg.
//
//   channel   dir  handshake                      contents
//   s_axis    in   s_axis_tvalid / s_axis_tready  one command item
//   m_axis    out  m_axis_tvalid / m_axis_tready  one pin action item
//   cfg       in   cfg_we_i                       register write, no read-back
//
// Result items leave at one per cycle from the output sequencer while m_axis_tready
// is high. A data byte gives eight data bit items, plus one for an error status or up to
// fifty-one more (init pulses and a wait status) after a good last byte; a start gives
// two, or one when no attempt is left, and other items give one.
// One descriptor slot sits in front of the sequencer, so the next item is taken
// while the current results drain. Reset clears the control state; the descriptor registers are not reset.
module passive_serial_fpga_configurator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // new_job, data_byte[8:1], nstatus_level, conf_done_level
  input  logic [1:0]  s_axis_tuser,  // kind
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // data_bit, status[3:1], attempts_left[7:4]
  output logic [2:0]  m_axis_tuser,  // action
  output logic        m_axis_tlast
);

  logic            pend_valid;
  psfc_pkg::desc_t pend_desc;
  logic            take;
  logic            data_bit;
  logic [2:0]      status;
  logic [3:0]      attempts_left;

  psfc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (s_axis_tuser),
    .new_job_i    (s_axis_tdata[0]),
    .data_byte_i  (s_axis_tdata[8:1]),
    .last_byte_i  (s_axis_tlast),
    .nstatus_i    (s_axis_tdata[9]),
    .conf_done_i  (s_axis_tdata[10]),
    .pend_valid_o (pend_valid),
    .pend_desc_o  (pend_desc),
    .take_i       (take)
  );

  psfc_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pend_valid_i    (pend_valid),
    .pend_desc_i     (pend_desc),
    .take_o          (take),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .action_o        (m_axis_tuser),
    .data_bit_o      (data_bit),
    .status_o        (status),
    .attempts_left_o (attempts_left),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {attempts_left, status, data_bit};

endmodule
